@@ hdl/csu_pkg.sv @@
// Shared types and constants for the cardinality sketch update core.
// Used by csu_ctrl, csu_datapath and the top level; depends on nothing.
package csu_pkg;

  localparam int HASH_W      = 64;  // add hash field
  localparam int IDX_FIELD_W = 14;  // merge index field
  localparam int VAL_W       = 6;   // register value / rank
  localparam int TALLY_W     = 15;  // zero register count
  localparam int SUM_W       = 63;  // harmonic sum, fixed point

  localparam int IN_DATA_W   = 88;  // 84 payload bits rounded up to bytes
  localparam int OUT_DATA_W  = 80;  // 79 payload bits rounded up to bytes

  // request kinds carried on in_tuser
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_MERGE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_RANK,
    ST_DELTA,
    ST_COMMIT
  } csu_state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_wr;  // zero one register of the store
    logic load;      // capture an accepted word
    logic fetch;     // read the addressed register, split the hash
    logic rank;      // resolve the offered value
    logic delta;     // compare and form the sum correction
    logic commit;    // write back, update totals, load the output
  } csu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;  // clearing pass at the final register
  } csu_status_t;

endpackage

@@ hdl/csu_ctrl.sv @@
// Sequencer for the cardinality sketch update core.
// Depends on csu_pkg; drives csu_datapath through csu_cmd_t.
module csu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  csu_pkg::csu_status_t status,
  output csu_pkg::csu_cmd_t    cmd
);
  import csu_pkg::*;

  csu_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_RANK;
      end
      ST_RANK: begin
        cmd.rank  = 1'b1;
        state_nxt = ST_DELTA;
      end
      ST_DELTA: begin
        cmd.delta = 1'b1;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the output register can take the result
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    priority if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_tready)     out_valid_nxt = 1'b0;
    else                     out_valid_nxt = out_valid_r;
  end

endmodule

@@ hdl/csu_datapath.sv @@
// Register store, rank extraction and running totals of the sketch core.
// Depends on csu_pkg; sequenced by csu_ctrl.
module csu_datapath #(
  parameter int PRECISION_BITS = 14,
  parameter int FRACTION_BITS  = 48
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  csu_pkg::csu_cmd_t            cmd,
  output csu_pkg::csu_status_t         status,
  input  logic                         req_type,
  input  logic [csu_pkg::HASH_W-1:0]   hash_value,
  input  logic [csu_pkg::IDX_FIELD_W-1:0] merge_index,
  input  logic [csu_pkg::VAL_W-1:0]    merge_value,
  output logic [csu_pkg::TALLY_W-1:0]  zero_registers,
  output logic [csu_pkg::SUM_W-1:0]    harmonic_sum,
  output logic                         register_raised
);
  import csu_pkg::*;

  localparam int REG_COUNT = 1 << PRECISION_BITS;
  localparam int REST_W    = HASH_W - PRECISION_BITS;
  localparam int CHUNKS    = (REST_W + 8) / 8;
  localparam int PAD_W     = CHUNKS * 8;
  localparam logic [VAL_W-1:0] MAX_RANK = VAL_W'(REST_W + 1);
  localparam logic [PRECISION_BITS+FRACTION_BITS:0] SUM_RESET_FULL =
    (PRECISION_BITS+FRACTION_BITS+1)'(1) << (PRECISION_BITS + FRACTION_BITS);
  localparam logic [SUM_W-1:0]   SUM_RESET   = SUM_W'(SUM_RESET_FULL);
  localparam logic [TALLY_W-1:0] TALLY_RESET = TALLY_W'(REG_COUNT);

  function automatic logic [SUM_W-1:0] term_of(input logic [VAL_W-1:0] v);
    logic [SUM_W-1:0] t;
    if (int'(v) > FRACTION_BITS) t = '0;
    else                         t = SUM_W'(64'd1 << (FRACTION_BITS - int'(v)));
    return t;
  endfunction

  logic [VAL_W-1:0] rank_mem [REG_COUNT];

  logic                      req_r;
  logic [REST_W-1:0]         rest_r;
  logic [PRECISION_BITS-1:0] idx_r;
  logic [VAL_W-1:0]          mval_r;
  logic [PRECISION_BITS-1:0] clr_cnt_r;
  logic [VAL_W-1:0]          rdata_r;
  logic [CHUNKS-1:0]         nz_r, nz_nxt;
  logic [2:0]                lz_r [CHUNKS];
  logic [2:0]                lz_nxt [CHUNKS];
  logic [VAL_W-1:0]          val_r, val_nxt;
  logic [VAL_W-1:0]          old_r;
  logic                      raised_r;
  logic                      was_zero_r;
  logic [SUM_W-1:0]          delta_r;
  logic [TALLY_W-1:0]        tally_r, tally_nxt;
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic [TALLY_W-1:0]        zero_out_r;
  logic [SUM_W-1:0]          sum_out_r;
  logic                      raised_out_r;
  logic [PAD_W-1:0]          padded;
  logic [PRECISION_BITS-1:0] idx_sel;

  assign status.clear_last = &clr_cnt_r;

  // a marker bit under the remaining hash bits caps the count at REST_W
  assign padded  = PAD_W'({rest_r, 1'b1}) << (PAD_W - REST_W - 1);
  assign idx_sel = (req_type == REQ_ADD) ? hash_value[HASH_W-1 -: PRECISION_BITS]
                                         : PRECISION_BITS'(merge_index);

  // per-chunk zero flags and leading zero counts
  always_comb begin
    logic [7:0] chunk;
    logic       found;
    for (int c = 0; c < CHUNKS; c++) begin
      chunk     = padded[PAD_W-1-8*c -: 8];
      nz_nxt[c] = |chunk;
      lz_nxt[c] = 3'd0;
      found     = 1'b0;
      for (int b = 7; b >= 0; b--) begin
        if (!found) begin
          if (chunk[b]) found = 1'b1;
          else          lz_nxt[c] = lz_nxt[c] + 3'd1;
        end
      end
    end
  end

  // first nonzero chunk from the top gives the rank; merges saturate
  always_comb begin
    val_nxt = MAX_RANK;
    if (req_r == REQ_ADD) begin
      for (int c = CHUNKS - 1; c >= 0; c--) begin
        if (nz_r[c]) val_nxt = VAL_W'(c * 8) + VAL_W'(lz_r[c]) + VAL_W'(1);
      end
    end else if (mval_r <= MAX_RANK) begin
      val_nxt = mval_r;
    end
  end

  assign tally_nxt = tally_r - TALLY_W'(was_zero_r);
  assign sum_nxt   = sum_r - delta_r;

  always_ff @(posedge clk) begin
    if (cmd.clear_wr)                rank_mem[clr_cnt_r] <= '0;
    else if (cmd.commit && raised_r) rank_mem[idx_r]     <= val_r;
    if (cmd.fetch) rdata_r <= rank_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      tally_r   <= TALLY_RESET;
      sum_r     <= SUM_RESET;
    end else begin
      if (cmd.clear_wr) clr_cnt_r <= clr_cnt_r + PRECISION_BITS'(1);
      if (cmd.commit) begin
        tally_r <= tally_nxt;
        sum_r   <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= req_type;
      rest_r <= hash_value[REST_W-1:0];
      idx_r  <= idx_sel;
      mval_r <= merge_value;
    end
    if (cmd.fetch) begin
      nz_r <= nz_nxt;
      lz_r <= lz_nxt;
    end
    if (cmd.rank) begin
      val_r <= val_nxt;
      old_r <= rdata_r;
    end
    if (cmd.delta) begin
      raised_r   <= val_r > old_r;
      was_zero_r <= (val_r > old_r) && (old_r == '0);
      delta_r    <= (val_r > old_r) ? term_of(old_r) - term_of(val_r) : '0;
    end
    if (cmd.commit) begin
      zero_out_r   <= tally_nxt;
      sum_out_r    <= sum_nxt;
      raised_out_r <= raised_r;
    end
  end

  assign zero_registers  = zero_out_r;
  assign harmonic_sum    = sum_out_r;
  assign register_raised = raised_out_r;

endmodule

@@ hdl/cardinality_sketch_update_core.sv @@
// Each accepted input word passes the fetch, rank, delta and commit states; its result
//   word is then registered at out_tvalid. Words are taken one at a time, as each runs
//   the read, rank, compare and write-back sequence on the register store; a waiting
//   result does not stop the next word from being accepted.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the store, one
//   register a cycle, 2^PRECISION_BITS registers (16384 by default), in_tready low.
module cardinality_sketch_update_core #(
  parameter int PRECISION_BITS = 14,  // store holds 2^PRECISION_BITS registers
  parameter int FRACTION_BITS  = 48   // fraction bits of the harmonic sum
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input words
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [63:0] hash_value, [77:64] merge_index, [83:78] merge_value, [87:84] zero
  input  logic [csu_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] req_type: 0 add a hash, 1 merge one register value
  input  logic                              in_tuser,
  // result words
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [14:0] zero_registers, [77:15] harmonic_sum, [78] register_raised, [79] zero
  output logic [csu_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import csu_pkg::*;

  csu_cmd_t             cmd;
  csu_status_t          status;
  logic [TALLY_W-1:0]   zero_registers;
  logic [SUM_W-1:0]     harmonic_sum;
  logic                 register_raised;

  // sequencer: clearing pass, one word at a time, output slot handshake
  csu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // store, rank extraction, zero count and harmonic sum
  csu_datapath #(
    .PRECISION_BITS (PRECISION_BITS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .req_type        (in_tuser),
    .hash_value      (in_tdata[63:0]),
    .merge_index     (in_tdata[77:64]),
    .merge_value     (in_tdata[83:78]),
    .zero_registers  (zero_registers),
    .harmonic_sum    (harmonic_sum),
    .register_raised (register_raised)
  );

  // pack the result fields, lowest first, zero fill to a whole byte
  assign out_tdata = OUT_DATA_W'({register_raised, harmonic_sum, zero_registers});

endmodule

@@ hdl/csu_checker.sv @@
// Port-level checks for cardinality_sketch_update_core, attached by bind.
// Depends on csu_pkg for the data width.
module csu_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [csu_pkg::OUT_DATA_W-1:0] out_tdata
);
  import csu_pkg::*;

  // reset starts the clearing pass: no word taken, no result shown
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!in_tready && !out_tvalid))
    else $error("ready or valid high right after reset");

  // one word at a time: an accepted word blocks the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken on consecutive cycles");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result word changed or dropped");

endmodule

bind cardinality_sketch_update_core csu_checker u_csu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ dv/tb.sv @@
// Self-checking bench for cardinality_sketch_update_core: add and merge words in,
// running zero count, harmonic sum and raise flag checked against an in-bench model.
// Depends on csu_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb;

  import csu_pkg::*;

  localparam int PREC      = 14;
  localparam int FRAC      = 48;
  localparam int REG_COUNT = 1 << PREC;
  localparam logic [VAL_W-1:0] MAX_RANK = VAL_W'(64 - PREC + 1);
  localparam int CYCLE_LIMIT = 400000;  // clearing pass plus a slow, stalled run, many times over
  localparam int IDLE_PCT    = 28;

  // one expected result word, unpacked into its fields
  typedef struct packed {
    logic               raised;
    logic [SUM_W-1:0]   sum;
    logic [TALLY_W-1:0] zeros;
  } totals_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = REQ_ADD;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // model of the sketch: rank per register and the two running totals
  logic [VAL_W-1:0]   rank_model [REG_COUNT];
  logic [TALLY_W-1:0] zero_model;
  logic [SUM_W-1:0]   sum_model;

  totals_t expected_totals [$];
  totals_t want_totals;
  totals_t got_totals;
  int      errors      = 0;
  int      cycle_count = 0;
  bit      steady      = 1'b0;  // set: neither side idles

  cardinality_sketch_update_core #(
    .PRECISION_BITS(PREC),
    .FRACTION_BITS (FRAC)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #10 clk = ~clk;

  // Bound the run; the clearing pass alone covers REG_COUNT registers.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic bit idle_now();
    return !steady && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // Stall the result side at random, never during the steady stretch.
  always @(posedge clk) begin
    out_tready <= !idle_now();
  end

  // Rank of a hash: leading zeros of the bits below the index, plus one.
  // All-zero remaining bits take the maximum rank.
  function automatic logic [VAL_W-1:0] rank_of_hash(input logic [HASH_W-1:0] hash);
    logic [HASH_W-1:0] rest;
    logic [VAL_W-1:0]  n;
    rest = hash << PREC;
    if (rest == '0) return MAX_RANK;
    n = VAL_W'(1);
    while (!rest[HASH_W-1]) begin
      rest = rest << 1;
      n++;
    end
    return n;
  endfunction

  // 2^-v in fixed point; terms finer than the fraction truncate to zero.
  function automatic logic [SUM_W-1:0] inverse_power(input logic [VAL_W-1:0] v);
    if (v > FRAC) return '0;
    return {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC - v);
  endfunction

  // Apply one accepted word to the model and return the totals it should report.
  function automatic totals_t sketch_update(input logic kind, input logic [HASH_W-1:0] hash,
                                            input logic [IDX_FIELD_W-1:0] idx_in,
                                            input logic [VAL_W-1:0] val_in);
    logic [PREC-1:0]  idx;
    logic [VAL_W-1:0] val;
    logic [VAL_W-1:0] old;
    totals_t          t;
    if (kind == REQ_ADD) begin
      idx = hash[HASH_W-1 -: PREC];
      val = rank_of_hash(hash);
    end else begin
      idx = idx_in[PREC-1:0];
      // saturate offered values above the largest possible rank
      val = (val_in > MAX_RANK) ? MAX_RANK : val_in;
    end
    old      = rank_model[idx];
    t.raised = 1'b0;
    if (val > old) begin
      t.raised        = 1'b1;
      rank_model[idx] = val;
      if (old == 0) zero_model = zero_model - 1'b1;
      sum_model = sum_model - inverse_power(old) + inverse_power(val);
    end
    t.zeros = zero_model;
    t.sum   = sum_model;
    return t;
  endfunction

  // Build a hash that lands on register idx with the given rank; bits below the
  // leading one are random.
  function automatic logic [HASH_W-1:0] hash_with_rank(input logic [PREC-1:0] idx,
                                                       input int rank);
    logic [HASH_W-PREC-1:0] rest;
    logic [HASH_W-PREC-1:0] low;
    low = (HASH_W-PREC)'({$urandom, $urandom});
    if (rank >= MAX_RANK) begin
      rest = '0;
    end else begin
      rest = {{(HASH_W-PREC-1){1'b0}}, 1'b1} << (HASH_W - PREC - rank);
      rest = rest | (low & (rest - 1'b1));
    end
    return {idx, rest};
  endfunction

  // Offer one word, hold it until the core takes it, then record its expected
  // totals. Leave tvalid high on return so back-to-back words need no second
  // assignment in the same step; drop it only when a gap is taken.
  task automatic send_word(input logic kind, input logic [HASH_W-1:0] hash,
                           input logic [IDX_FIELD_W-1:0] idx, input logic [VAL_W-1:0] val);
    if (idle_now()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while (idle_now()) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, val, idx, hash};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_totals.push_back(sketch_update(kind, hash, idx, val));
  endtask

  task automatic send_add(input logic [HASH_W-1:0] hash);
    // fill the unused merge fields with noise
    send_word(REQ_ADD, hash, IDX_FIELD_W'($urandom), VAL_W'($urandom));
  endtask

  task automatic send_merge(input logic [IDX_FIELD_W-1:0] idx, input logic [VAL_W-1:0] val);
    // fill the unused hash with noise
    send_word(REQ_MERGE, {$urandom, $urandom}, idx, val);
  endtask

  // Check each result word against the oldest expectation, field by field.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_totals.zeros  = out_tdata[14:0];
      got_totals.sum    = out_tdata[77:15];
      got_totals.raised = out_tdata[78];
      if (expected_totals.size() == 0) begin
        $display("%0t: unexpected result word, actual %h", $time, out_tdata);
        errors++;
      end else begin
        want_totals = expected_totals.pop_front();
        if (got_totals.zeros !== want_totals.zeros) begin
          $display("%0t: zero_registers expected %0d actual %0d",
                   $time, want_totals.zeros, got_totals.zeros);
          errors++;
        end
        if (got_totals.sum !== want_totals.sum) begin
          $display("%0t: harmonic_sum expected %h actual %h",
                   $time, want_totals.sum, got_totals.sum);
          errors++;
        end
        if (got_totals.raised !== want_totals.raised) begin
          $display("%0t: register_raised expected %0b actual %0b",
                   $time, want_totals.raised, got_totals.raised);
          errors++;
        end
      end
    end
  end

  // Hold reset, then seed the model with the post-reset state.
  task automatic test_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (rank_model[i]) rank_model[i] = '0;
    zero_model = TALLY_W'(REG_COUNT);
    sum_model  = SUM_W'(REG_COUNT) << FRAC;
  endtask

  // Hash extremes and ranks around the truncation point of the sum.
  task automatic test_add_extremes();
    send_add(64'h0);                     // all-zero rest: maximum rank, term truncated
    send_add(64'hFFFF_FFFF_FFFF_FFFF);   // top register, rank one
    send_add(hash_with_rank(14'd1, 48)); // smallest term that still counts
    send_add(hash_with_rank(14'd2, 49)); // first truncated term
    send_add(hash_with_rank(14'd3, 50));
    send_add(hash_with_rank(14'd4, 1));
    send_add(hash_with_rank(14'd4, 1));  // same rank again: no raise
    send_add(hash_with_rank(14'd4, 7));  // raise a nonzero register
    send_add(hash_with_rank(14'd4, 3));  // lower rank: no raise
    send_add({14'd5, 50'h1});            // single low bit: rank 50
    send_add(hash_with_rank(14'd0, 20)); // below the stored maximum
  endtask

  // Merge values at and above the maximum rank, zero, and raises of stored values.
  task automatic test_merge_cases();
    send_merge(14'd100, 6'd63);   // saturates to the maximum rank
    send_merge(14'd101, 6'd52);   // just above the maximum rank
    send_merge(14'd102, 6'd0);    // zero never raises
    send_merge(14'd100, 6'd51);   // equal to stored: no raise
    send_merge(14'd16383, 6'd2);  // top register already at one: raise
    send_merge(14'd4, 6'd5);      // lower than stored
    send_merge(14'd4, 6'd48);
    send_merge(14'd200, 6'd42);
    send_merge(14'd200, 6'd21);
    send_merge(14'd8191, 6'd1);
  endtask

  // Mixed random words. Half the indices of the ranked adds and merges fall in a small hot
  // set so registers are revisited; ranked adds draw ranks evenly, one word in four is a raw hash.
  task automatic run_random(input int count);
    logic [PREC-1:0] idx;
    for (int n = 0; n < count; n++) begin
      idx = ($urandom_range(0, 1) == 0) ? PREC'($urandom_range(0, 63)) : PREC'($urandom);
      case ($urandom_range(0, 3))
        0: send_add({$urandom, $urandom});
        1, 2: send_add(hash_with_rank(idx, $urandom_range(1, MAX_RANK)));
        default: send_merge(IDX_FIELD_W'(idx), VAL_W'($urandom_range(0, 63)));
      endcase
    end
  endtask

  task automatic test_random_traffic();
    run_random(1000);
  endtask

  // Back-to-back stretch with both sides always ready.
  task automatic test_steady_stream();
    steady = 1'b1;
    run_random(200);
    steady = 1'b0;
  endtask

  initial begin
    test_reset();
    test_add_extremes();
    test_merge_cases();
    test_random_traffic();
    test_steady_stream();
    in_tvalid <= 1'b0;
    // drain, then give the pipeline its latency and some margin
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
